FILE: rtl/stw_pkg.sv
// ----------------------------------------------------------------------------
// stw_pkg: shared constants and types for the strided tensor address walker
// Widths of the walk state, the configuration registers and their indexes.
// ----------------------------------------------------------------------------
package stw_pkg;

  // Walk geometry
  localparam int MAX_RANK  = 4;
  localparam int DIM_BITS  = 16;
  localparam int ADDR_BITS = 48;

  // Product of one index and one stride, kept no wider than an address
  localparam int PROD_W = (2 * DIM_BITS < ADDR_BITS) ? 2 * DIM_BITS : ADDR_BITS;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int RANK_W     = 3;
  localparam int BASE_W     = 32;
  localparam int ESL_W      = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANK           = 3'd0,
    CFG_DIM_SIZES      = 3'd1,
    CFG_DIM_STRIDES    = 3'd2,
    CFG_BASE_OFFSET    = 3'd3,
    CFG_ELEM_SIZE_LOG2 = 3'd4
  } cfg_reg_e;

  // Register reset values
  localparam logic [RANK_W-1:0]     RANK_RST    = 3'd4;
  localparam logic [CFG_DATA_W-1:0] SIZES_RST   = 64'h0001_0001_0001_0001;
  localparam logic [CFG_DATA_W-1:0] STRIDES_RST = 64'h0;
  localparam logic [BASE_W-1:0]     BASE_RST    = 32'h0;
  localparam logic [ESL_W-1:0]      ESL_RST     = 2'd2;

endpackage

FILE: rtl/stw_in_if.sv
// ----------------------------------------------------------------------------
// stw_in_if: request channel of the address walker
// One beat asks for the addresses of the next element when advance is set.
// ----------------------------------------------------------------------------
interface stw_in_if;
  logic valid;
  logic ready;
  logic advance;

  modport source (output valid, output advance, input ready);
  modport sink   (input valid, input advance, output ready);
endinterface

FILE: rtl/stw_out_if.sv
// ----------------------------------------------------------------------------
// stw_out_if: address channel of the address walker
// One beat carries the source and destination byte addresses of one element.
// ----------------------------------------------------------------------------
interface stw_out_if;
  logic                          valid;
  logic                          ready;
  logic [stw_pkg::ADDR_BITS-1:0] source_addr;
  logic [stw_pkg::ADDR_BITS-1:0] dest_addr;
  logic                          last;

  modport source (output valid, output source_addr, output dest_addr, output last,
                  input ready);
  modport sink   (input valid, input source_addr, input dest_addr, input last,
                  output ready);
endinterface

FILE: rtl/strided_tensor_address_walker_core.sv
// ----------------------------------------------------------------------------
// strided_tensor_address_walker_core: strided N-D address generator
// Walks a strided tensor view in row-major order and emits per element the
// source byte address and the contiguous destination byte address.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   : request beats. A beat with advance set steps the walk and yields
//            one address beat; a beat with advance clear is taken and dropped.
//   out_o  : address beats (source_addr, dest_addr, last). last marks the
//            final element; the index counters then wrap to zero.
//   cfg_*  : register writes, one per cycle with cfg_we_i, only while idle.
// Path    : a request beat passes the counter/multiply stage, then the
//           sum/output register, before its address beat is valid.
// Rate    : one element per cycle while out_o accepts beats; the index
//           counters step through a combinational carry chain, the
//           index-times-stride products are registered before the final sum.
// Stall   : with out_o stalled, one more request is held in the product
//           stage; in_i.ready then drops until the output register frees.
// Reset   : registers return to their default view (rank 4, all sizes 1,
//           strides 0, base 0, four-byte elements), counters clear, both
//           stages empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
module strided_tensor_address_walker_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  stw_in_if.sink                           in_i,
  stw_out_if.source                        out_o,
  input  logic                             cfg_we_i,
  input  logic [stw_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [stw_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  typedef logic [stw_pkg::DIM_BITS-1:0]  dim_t;
  typedef logic [stw_pkg::ADDR_BITS-1:0] addr_t;
  typedef logic [stw_pkg::PROD_W-1:0]    prod_t;

  // Configuration registers
  logic [stw_pkg::RANK_W-1:0]     rank_q;
  logic [stw_pkg::CFG_DATA_W-1:0] sizes_q;
  logic [stw_pkg::CFG_DATA_W-1:0] strides_q;
  logic [stw_pkg::BASE_W-1:0]     base_q;
  logic [stw_pkg::ESL_W-1:0]      esl_q;

  // Walk state
  dim_t  idx_q [stw_pkg::MAX_RANK];
  dim_t  idx_d [stw_pkg::MAX_RANK];
  addr_t cnt_q, cnt_d;

  // Product stage
  logic  s1_v_q;
  prod_t s1_prod_q [stw_pkg::MAX_RANK];
  addr_t s1_dest_q;
  logic  s1_last_q;

  // Output register
  logic  out_v_q;
  addr_t out_src_q, out_dst_q;
  logic  out_last_q;

  // Per-slot decode
  logic  act    [stw_pkg::MAX_RANK];
  dim_t  size_r [stw_pkg::MAX_RANK];
  dim_t  stride [stw_pkg::MAX_RANK];
  logic  wrap   [stw_pkg::MAX_RANK];
  dim_t  nxt    [stw_pkg::MAX_RANK];
  prod_t prod   [stw_pkg::MAX_RANK];
  logic  at_end;
  addr_t dest_val;
  addr_t src_val;

  // Handshake
  logic s2_en;
  logic push;

  assign s2_en      = !out_v_q || out_o.ready;
  assign in_i.ready = !s1_v_q || s2_en;
  assign push       = in_i.valid && in_i.ready && in_i.advance;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q    <= stw_pkg::RANK_RST;
      sizes_q   <= stw_pkg::SIZES_RST;
      strides_q <= stw_pkg::STRIDES_RST;
      base_q    <= stw_pkg::BASE_RST;
      esl_q     <= stw_pkg::ESL_RST;
    end else if (cfg_we_i) begin
      unique case (stw_pkg::cfg_reg_e'(cfg_idx_i))
        stw_pkg::CFG_RANK:           rank_q    <= cfg_data_i[stw_pkg::RANK_W-1:0];
        stw_pkg::CFG_DIM_SIZES:      sizes_q   <= cfg_data_i;
        stw_pkg::CFG_DIM_STRIDES:    strides_q <= cfg_data_i;
        stw_pkg::CFG_BASE_OFFSET:    base_q    <= cfg_data_i[stw_pkg::BASE_W-1:0];
        stw_pkg::CFG_ELEM_SIZE_LOG2: esl_q     <= cfg_data_i[stw_pkg::ESL_W-1:0];
        default: ;
      endcase
    end
  end

  // Slot decode, end detect, carry chain and products
  always_comb begin
    logic                          carry;
    logic [2*stw_pkg::DIM_BITS-1:0] full;
    dim_t                          size_e;
    dim_t                          last_i;
    at_end = 1'b1;
    carry  = 1'b1;
    for (int k = 0; k < stw_pkg::MAX_RANK; k++) begin
      // rank 0 still walks the innermost slot; slots past rank are idle
      act[k]    = (k == 0) || (int'(rank_q) > k);
      size_r[k] = dim_t'(sizes_q >> (k * stw_pkg::DIM_BITS));
      stride[k] = dim_t'(strides_q >> (k * stw_pkg::DIM_BITS));
      size_e    = (size_r[k] == '0) ? dim_t'(1) : size_r[k];
      last_i    = size_e - dim_t'(1);
      if (act[k] && (idx_q[k] != last_i)) begin
        at_end = 1'b0;
      end
      nxt[k]  = idx_q[k] + dim_t'(1);
      wrap[k] = (nxt[k] == '0) || (nxt[k] >= size_e);
      full    = (2*stw_pkg::DIM_BITS)'(idx_q[k]) * (2*stw_pkg::DIM_BITS)'(stride[k]);
      prod[k] = act[k] ? prod_t'(full) : '0;
    end

    // next counters: clear on wrap of the whole view, else ripple carry
    for (int k = 0; k < stw_pkg::MAX_RANK; k++) begin
      idx_d[k] = idx_q[k];
      if (at_end) begin
        idx_d[k] = '0;
      end else if (act[k] && carry) begin
        idx_d[k] = wrap[k] ? '0 : nxt[k];
        carry    = wrap[k];
      end
    end
    cnt_d    = at_end ? '0 : cnt_q + addr_t'(1);
    dest_val = cnt_q << esl_q;
  end

  // Walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < stw_pkg::MAX_RANK; k++) begin
        idx_q[k] <= '0;
      end
      cnt_q <= '0;
    end else if (push) begin
      idx_q <= idx_d;
      cnt_q <= cnt_d;
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (push) begin
        s1_v_q <= 1'b1;
      end else if (s2_en) begin
        s1_v_q <= 1'b0;
      end
      if (s1_v_q && s2_en) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Source address sum
  always_comb begin
    addr_t sum;
    sum = '0;
    for (int k = 0; k < stw_pkg::MAX_RANK; k++) begin
      sum = sum + addr_t'(s1_prod_q[k]);
    end
    src_val = addr_t'(base_q) + (sum << esl_q);
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (push) begin
      s1_prod_q <= prod;
      s1_dest_q <= dest_val;
      s1_last_q <= at_end;
    end
    if (s1_v_q && s2_en) begin
      out_src_q  <= src_val;
      out_dst_q  <= s1_dest_q;
      out_last_q <= s1_last_q;
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.source_addr = out_src_q;
  assign out_o.dest_addr   = out_dst_q;
  assign out_o.last        = out_last_q;

  // Checks
  a_wrap_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && at_end |=> cnt_q == '0)
    else $error("element count not cleared after last element");

  a_count_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !at_end |=> cnt_q == $past(cnt_q) + addr_t'(1))
    else $error("element count did not step by one");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> s1_v_q)
    else $error("accepted beat lost before product stage");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && out_v_q && !out_o.ready |-> !in_i.ready)
    else $error("request taken while both stages are full and stalled");

endmodule
